// File: rtl/mfr_pkg.sv
package mfr_pkg;

  // Start-of-frame delimiter and the fixed size of the address field.
  localparam logic [7:0] START_BYTE = 8'h68;
  localparam int unsigned ADDR_BYTES = 7;
  localparam int unsigned ADDR_W = 8 * ADDR_BYTES;

  // Position within the frame.
  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_KIND = 4'd1,
    PH_ADDR = 4'd2,
    PH_CTRL = 4'd3,
    PH_LEN  = 4'd4,
    PH_DATA = 4'd5,
    PH_SUM  = 4'd6,
    PH_STOP = 4'd7,
    PH_DONE = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       burst_end;
  } in_item_t;

  typedef struct packed {
    logic              is_summary;
    logic [7:0]        payload_byte;
    logic [7:0]        meter_kind;
    logic [ADDR_W-1:0] meter_address;
    logic [7:0]        control_code;
    logic [7:0]        payload_length;
    logic [7:0]        received_sum;
    logic [7:0]        stop_value;
    logic              frame_complete;
    logic              checksum_ok;
  } out_item_t;

endpackage

// File: rtl/mfr_parser.sv
module mfr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  mfr_pkg::in_item_t  item,
  output logic             res_valid,
  output mfr_pkg::out_item_t res
);
  import mfr_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        count_r, count_nxt;
  logic [7:0]        run_sum_r, run_sum_nxt;
  logic [7:0]        kind_r, kind_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        rsum_r, rsum_nxt;

  // Frame state registers, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      count_r   <= '0;
      run_sum_r <= '0;
      kind_r    <= '0;
      addr_r    <= '0;
      ctrl_r    <= '0;
      len_r     <= '0;
      rsum_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      run_sum_r <= run_sum_nxt;
      kind_r    <= kind_nxt;
      addr_r    <= addr_nxt;
      ctrl_r    <= ctrl_nxt;
      len_r     <= len_nxt;
      rsum_r    <= rsum_nxt;
    end
  end

  // Per-byte state update and result selection.
  always_comb begin
    logic       done_now;
    logic       data_out;
    phase_t     p;
    logic [7:0] b;
    b           = item.rx_byte;
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    run_sum_nxt = run_sum_r;
    kind_nxt    = kind_r;
    addr_nxt    = addr_r;
    ctrl_nxt    = ctrl_r;
    len_nxt     = len_r;
    rsum_nxt    = rsum_r;
    done_now    = 1'b0;
    data_out    = 1'b0;
    res_valid   = 1'b0;
    res         = '0;

    case (phase_r)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          run_sum_nxt = START_BYTE;
          count_nxt   = '0;
          kind_nxt    = '0;
          addr_nxt    = '0;
          ctrl_nxt    = '0;
          len_nxt     = '0;
          rsum_nxt    = '0;
          phase_nxt   = PH_KIND;
        end
      end
      PH_KIND: begin
        kind_nxt    = b;
        run_sum_nxt = run_sum_r + b;
        count_nxt   = '0;
        phase_nxt   = PH_ADDR;
      end
      PH_ADDR: begin
        addr_nxt    = addr_r | ({{(ADDR_W-8){1'b0}}, b} << {count_r[2:0], 3'b000});
        run_sum_nxt = run_sum_r + b;
        count_nxt   = count_r + 8'd1;
        if (count_nxt >= 8'(ADDR_BYTES)) begin
          phase_nxt = PH_CTRL;
        end
      end
      PH_CTRL: begin
        ctrl_nxt    = b;
        run_sum_nxt = run_sum_r + b;
        phase_nxt   = PH_LEN;
      end
      PH_LEN: begin
        len_nxt     = b;
        run_sum_nxt = run_sum_r + b;
        count_nxt   = '0;
        phase_nxt   = (b == 8'd0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        run_sum_nxt = run_sum_r + b;
        count_nxt   = count_r + 8'd1;
        if (count_nxt >= len_r) begin
          phase_nxt = PH_SUM;
        end
        data_out = 1'b1;
      end
      PH_SUM: begin
        rsum_nxt  = b;
        phase_nxt = PH_STOP;
      end
      PH_STOP: begin
        phase_nxt = PH_DONE;
        done_now  = 1'b1;
      end
      default: begin
      end
    endcase

    // Summary fields carry the frame registers as updated by this byte.
    res.meter_kind     = kind_nxt;
    res.meter_address  = addr_nxt;
    res.control_code   = ctrl_nxt;
    res.payload_length = len_nxt;
    res.received_sum   = rsum_nxt;
    p = phase_nxt;

    if (done_now) begin
      res_valid          = 1'b1;
      res.is_summary     = 1'b1;
      res.stop_value     = b;
      res.frame_complete = 1'b1;
      res.checksum_ok    = (run_sum_nxt == rsum_nxt);
      if (item.burst_end) begin
        phase_nxt = PH_HUNT;
      end
    end else if (item.burst_end) begin
      phase_nxt = PH_HUNT;
      // A frame cut short by the burst end still gets its summary.
      if (p != PH_HUNT && p != PH_DONE) begin
        res_valid      = 1'b1;
        res.is_summary = 1'b1;
      end
    end else if (data_out) begin
      res              = '0;
      res_valid        = 1'b1;
      res.payload_byte = b;
    end
  end

endmodule

// File: rtl/mfr_out_buf.sv
module mfr_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mfr_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output mfr_pkg::out_item_t out_data
);
  import mfr_pkg::*;

  out_item_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = mem_r[rd_ptr_r];

  // Two-entry result queue so the parser keeps taking bytes while the
  // receiver holds off a transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/meter_frame_receiver.sv
// Receiver for meter frames carried in a byte stream.
// Input channel: one received byte per transaction (in_data.rx_byte), with
// in_data.burst_end marking the last byte of a burst. Bytes before the first
// start byte are dropped; after a frame's stop byte, bytes are ignored until
// the burst ends.
// Output channel: one transaction per data byte (is_summary 0), then one
// frame summary (is_summary 1) after the stop byte, or at the burst end if the
// frame was cut short. A burst end on a data byte yields only the summary.
// Throughput: one byte per cycle while in_stall is low; the per-byte state
// update is a single registered step. Each result is written into the queue
// as its byte is accepted and reaches out_valid once earlier results are taken.
// Stall: results wait in a two-entry queue; in_stall rises only when both
// entries are occupied, so a stalled receiver stops input after two results.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to
// hunting for a start byte with all frame registers cleared.
module meter_frame_receiver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mfr_pkg::out_item_t out_data
);
  import mfr_pkg::*;

  logic      accept;
  logic      res_valid;
  out_item_t res;
  logic      full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  mfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  mfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
